### hdl/ocdc_pkg.sv
`default_nettype none

package ocdc_pkg;

    // calendar limits
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [9:0]  DAYS_NORMAL   = 10'd365;
    localparam logic [9:0]  DAYS_LEAP     = 10'd366;
    localparam int unsigned NUM_BOUNDS    = 11;

    // multiplicative inverse of 25 modulo 2**16 and the largest product
    // that a multiple of 25 can give
    localparam logic [15:0] INV25_MOD16   = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT   = 16'(65535 / 25);

    typedef enum logic {
        MODE_ORDINAL  = 1'b0,
        MODE_CALENDAR = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_YEAR  = 2'd1,
        ERR_MONTH = 2'd2,
        ERR_DAY   = 2'd3
    } t_err;

    typedef struct packed {
        t_mode       mode;
        logic [13:0] year;
        logic [6:0]  month_in;
        logic [9:0]  day_in;
    } t_in_word;

    typedef struct packed {
        logic        valid_res;
        t_err        error_code;
        logic [3:0]  month_out;
        logic [4:0]  day_of_month;
        logic        leap;
    } t_out_word;

    // last day of year of month idx+1, idx 0..10
    function automatic logic [8:0] month_end(input logic [3:0] idx, input logic lp);
        logic [8:0] e;
        case (idx)
            4'd0:    e = 9'd31;
            4'd1:    e = 9'd59;
            4'd2:    e = 9'd90;
            4'd3:    e = 9'd120;
            4'd4:    e = 9'd151;
            4'd5:    e = 9'd181;
            4'd6:    e = 9'd212;
            4'd7:    e = 9'd243;
            4'd8:    e = 9'd273;
            4'd9:    e = 9'd304;
            4'd10:   e = 9'd334;
            default: e = 9'd365;
        endcase
        if (lp && idx != 4'd0) begin
            e = e + 9'd1;
        end
        return e;
    endfunction

    // days in month 1..12
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic lp);
        logic [4:0] l;
        case (mon)
            4'd2:    l = lp ? 5'd29 : 5'd28;
            4'd4:    l = 5'd30;
            4'd6:    l = 5'd30;
            4'd9:    l = 5'd30;
            4'd11:   l = 5'd30;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

    // gregorian leap rule; divisibility by 25 via modular inverse
    function automatic logic is_leap(input logic [13:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = {18'd0, y} * {16'd0, INV25_MOD16};
        div25 = (prod[15:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || y[3:2] == 2'b00);
    endfunction

endpackage

`default_nettype wire

### hdl/ocdc_calc.sv
`default_nettype none

module ocdc_calc (
    input  var ocdc_pkg::t_in_word  i_word,
    output var ocdc_pkg::t_out_word o_word
);

    logic                              lp;
    logic [9:0]                        ylen;
    logic                              ord_year_ok;
    logic                              ord_day_ok;
    logic                              mon_ok;
    logic [4:0]                        mlen;
    logic                              cal_day_ok;
    logic [ocdc_pkg::NUM_BOUNDS-1:0]   past;
    logic [3:0]                        idx;
    logic [8:0]                        prev;
    logic [9:0]                        diff;

    always_comb begin
        lp          = ocdc_pkg::is_leap(i_word.year);
        ylen        = lp ? ocdc_pkg::DAYS_LEAP : ocdc_pkg::DAYS_NORMAL;
        ord_year_ok = (i_word.year != 14'd0) && (i_word.year <= ocdc_pkg::YEAR_MAX);
        ord_day_ok  = (i_word.day_in != 10'd0) && (i_word.day_in <= ylen);
        mon_ok      = (i_word.month_in >= 7'd1) && (i_word.month_in <= 7'd12);
        mlen        = ocdc_pkg::month_len(i_word.month_in[3:0], lp);
        cal_day_ok  = (i_word.day_in != 10'd0) && (i_word.day_in <= {5'd0, mlen});

        // month boundaries passed, compared in parallel
        for (int m = 0; m < ocdc_pkg::NUM_BOUNDS; m++) begin
            past[m] = (i_word.day_in > {1'b0, ocdc_pkg::month_end(4'(m), lp)});
        end
        idx = 4'd0;
        for (int m = 0; m < ocdc_pkg::NUM_BOUNDS; m++) begin
            idx = idx + {3'd0, past[m]};
        end
        prev = (idx == 4'd0) ? 9'd0 : ocdc_pkg::month_end(idx - 4'd1, lp);
        diff = i_word.day_in - {1'b0, prev};

        o_word              = '0;
        o_word.leap         = lp;
        o_word.error_code   = ocdc_pkg::ERR_NONE;
        if (i_word.mode == ocdc_pkg::MODE_ORDINAL) begin
            if (!ord_year_ok) begin
                o_word.error_code = ocdc_pkg::ERR_YEAR;
            end else if (!ord_day_ok) begin
                o_word.error_code = ocdc_pkg::ERR_DAY;
            end else begin
                o_word.month_out    = idx + 4'd1;
                o_word.day_of_month = diff[4:0];
            end
        end else begin
            if (i_word.year == 14'd0) begin
                o_word.error_code = ocdc_pkg::ERR_YEAR;
            end else if (!mon_ok) begin
                o_word.error_code = ocdc_pkg::ERR_MONTH;
            end else if (!cal_day_ok) begin
                o_word.error_code = ocdc_pkg::ERR_DAY;
            end else begin
                o_word.month_out    = i_word.month_in[3:0];
                o_word.day_of_month = i_word.day_in[4:0];
            end
        end
        o_word.valid_res = (o_word.error_code == ocdc_pkg::ERR_NONE);
    end

endmodule

`default_nettype wire

### hdl/ordinal_calendar_date_check_top.sv
// channel  | valid    | ready    | word
// ---------+----------+----------+-----------------------------------
// in       | i_valid  | o_ready  | i_data  (mode, year, month, day)
// out      | o_valid  | i_ready  | o_data  (valid, error, month, day, leap)
//
// accepted word passes the input register, then the output register; one word per cycle
// sustained while i_ready stays high; the word lands in the input register, and its check
// and split result sits in the output register
// i_rst_n is synchronous active low and empties both stages
// a stall on i_ready holds the output register; the input stage keeps filling
// until both stages are occupied, then o_ready drops
`default_nettype none

module ordinal_calendar_date_check_top (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_valid,
    output var logic                o_ready,
    input  var ocdc_pkg::t_in_word  i_data,
    output var logic                o_valid,
    input  var logic                i_ready,
    output var ocdc_pkg::t_out_word o_data
);

    // input stage
    logic                r_in_vld;
    logic                n_in_vld;
    ocdc_pkg::t_in_word  r_in;
    // output stage
    logic                r_out_vld;
    logic                n_out_vld;
    ocdc_pkg::t_out_word r_out;
    ocdc_pkg::t_out_word calc_word;
    logic                advance;

    // the output register frees up when empty or when its word is taken
    assign advance = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || advance;

    ocdc_calc u_calc (
        .i_word (r_in),
        .o_word (calc_word)
    );

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        if (o_ready) begin
            n_in_vld = i_valid;
        end
        if (advance) begin
            n_out_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
        if (advance && r_in_vld) begin
            r_out <= calc_word;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### hdl/ocdc_checker.sv
`default_nettype none

module ocdc_checker (
    input var logic                i_clk,
    input var logic                i_rst_n,
    input var logic                i_valid,
    input var logic                o_ready,
    input var ocdc_pkg::t_in_word  i_data,
    input var logic                o_valid,
    input var logic                i_ready,
    input var ocdc_pkg::t_out_word o_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed under stall");

    a_valid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.valid_res == (o_data.error_code == ocdc_pkg::ERR_NONE)))
        else $error("valid flag disagrees with error code");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.valid_res |-> o_data.month_out == 4'd0 && o_data.day_of_month == 5'd0)
        else $error("rejected date carries month or day");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.valid_res |-> o_data.month_out >= 4'd1 && o_data.month_out <= 4'd12
            && o_data.day_of_month != 5'd0)
        else $error("accepted date out of range");

    // a word accepted into an empty block passes the input and output registers to o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid && $past(i_rst_n) && $past(!i_valid) |=> ##1 o_valid)
        else $error("result word missing after two cycles");

endmodule

bind ordinal_calendar_date_check_top ocdc_checker u_ocdc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire
